// ===== design/mffd_pkg.sv =====
// Shared types and constants of the motor feedback frame decoder.
// Used by every decoder module and by the testbench.
`default_nettype none

package mffd_pkg;

  // Number of motor slots that hold filter and turn state.
  localparam int unsigned SLOT_COUNT = 4;
  // Number of identifier registers on the configuration port.
  localparam int unsigned ID_REGS = 4;
  localparam logic [10:0] ID_RESET_BASE = 11'd321;

  // Queue between the classifying front and the arithmetic back.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QUEUE_CW = $clog2(QUEUE_DEPTH + 1);

  // 2 * round(pi * 2^32).
  localparam logic [34:0] TWO_PI_Q32 = 35'd26986075410;
  // round(pi * 2^32) = 1143 * (180 * 2^16) + SPD_REM.
  localparam logic [10:0] SPD_INT = 11'd1143;
  localparam logic [23:0] SPD_REM = 24'd9661065;
  // Half of 180 * 2^16, for rounding to nearest.
  localparam logic [22:0] SPD_HALF = 23'd5898240;
  localparam logic [7:0] SPD_DIV = 8'd180;
  // floor(2^32 / 180); the quotient it gives is low by at most one.
  localparam logic [24:0] RECIP180 = 25'd23860929;
  // ceil(2^35 / 10); exact division by ten for any 32-bit dividend.
  localparam logic [31:0] RECIP10 = 32'hCCCCCCCD;
  localparam logic [50:0] ROUND_Q32 = 51'h0_8000_0000;
  localparam logic [49:0] ROUND_Q16 = 50'd32768;
  localparam logic signed [16:0] TURN_HALF = 17'sd32768;

  typedef enum logic [2:0] {
    CFG_ACTIVE_SLOTS = 3'd0,
    CFG_SLOT0_ID     = 3'd1,
    CFG_SLOT1_ID     = 3'd2,
    CFG_SLOT2_ID     = 3'd3,
    CFG_SLOT3_ID     = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [10:0] frame_id;
    logic [7:0]  temperature_byte;
    logic [7:0]  current_low_byte;
    logic [7:0]  current_high_byte;
    logic [7:0]  speed_low_byte;
    logic [7:0]  speed_high_byte;
    logic [7:0]  encoder_low_byte;
    logic [7:0]  encoder_high_byte;
  } frame_t;

  // A classified frame as it waits in the queue.
  typedef struct packed {
    logic       matched;
    logic [1:0] slot;
    frame_t     frame;
  } entry_t;

endpackage

`default_nettype wire

// ===== design/mffd_channels.sv =====
// Handshake channel interfaces of the motor feedback frame decoder:
// received frames, decoded results and configuration writes. No dependencies.
`default_nettype none

interface mffd_frame_if;
  logic        valid;
  logic        ready;
  logic [10:0] frame_id;
  logic [7:0]  temperature_byte;
  logic [7:0]  current_low_byte;
  logic [7:0]  current_high_byte;
  logic [7:0]  speed_low_byte;
  logic [7:0]  speed_high_byte;
  logic [7:0]  encoder_low_byte;
  logic [7:0]  encoder_high_byte;

  modport source (
    output valid, frame_id, temperature_byte, current_low_byte, current_high_byte,
           speed_low_byte, speed_high_byte, encoder_low_byte, encoder_high_byte,
    input  ready
  );
  modport sink (
    input  valid, frame_id, temperature_byte, current_low_byte, current_high_byte,
           speed_low_byte, speed_high_byte, encoder_low_byte, encoder_high_byte,
    output ready
  );
endinterface

interface mffd_result_if;
  logic               valid;
  logic               ready;
  logic               matched;
  logic [1:0]         slot_index;
  logic [7:0]         temperature;
  logic signed [23:0] filtered_current;
  logic signed [26:0] speed_rad;
  logic [15:0]        encoder_value;
  logic [18:0]        single_turn_angle;
  logic signed [15:0] turn_count;
  logic signed [34:0] multi_turn_angle;

  modport source (
    output valid, matched, slot_index, temperature, filtered_current, speed_rad,
           encoder_value, single_turn_angle, turn_count, multi_turn_angle,
    input  ready
  );
  modport sink (
    input  valid, matched, slot_index, temperature, filtered_current, speed_rad,
           encoder_value, single_turn_angle, turn_count, multi_turn_angle,
    output ready
  );
endinterface

interface mffd_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [10:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== design/mffd_front.sv =====
// Front of the decoder: configuration registers and slot matching.
// Depends on mffd_pkg and the channel interfaces.
`default_nettype none

module mffd_front
  import mffd_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  mffd_cfg_if.sink    cfg_i,
  mffd_frame_if.sink  frame_i,
  output logic        push_valid_o,
  output entry_t      push_entry_o,
  input  wire logic   push_ready_i
);

  logic [2:0]  active_q;
  logic [10:0] slot_id_q [ID_REGS];

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
      for (int i = 0; i < ID_REGS; i++) begin
        slot_id_q[i] <= 11'(ID_RESET_BASE + 11'(i));
      end
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_ACTIVE_SLOTS: active_q     <= cfg_i.data[2:0];
        CFG_SLOT0_ID:     slot_id_q[0] <= cfg_i.data;
        CFG_SLOT1_ID:     slot_id_q[1] <= cfg_i.data;
        CFG_SLOT2_ID:     slot_id_q[2] <= cfg_i.data;
        CFG_SLOT3_ID:     slot_id_q[3] <= cfg_i.data;
        default: ;
      endcase
    end
  end

  logic [2:0] search_n;
  logic       hit;
  logic [1:0] hit_slot;

  // Walk from the top down so that the lowest matching slot wins.
  always_comb begin
    search_n = (active_q > 3'(SLOT_COUNT)) ? 3'(SLOT_COUNT) : active_q;
    hit      = 1'b0;
    hit_slot = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if ((3'(i) < search_n) && (slot_id_q[i] == frame_i.frame_id)) begin
        hit      = 1'b1;
        hit_slot = 2'(i);
      end
    end
  end

  assign push_valid_o  = frame_i.valid;
  assign frame_i.ready = push_ready_i;

  always_comb begin
    push_entry_o.matched                  = hit;
    push_entry_o.slot                     = hit_slot;
    push_entry_o.frame.frame_id           = frame_i.frame_id;
    push_entry_o.frame.temperature_byte   = frame_i.temperature_byte;
    push_entry_o.frame.current_low_byte   = frame_i.current_low_byte;
    push_entry_o.frame.current_high_byte  = frame_i.current_high_byte;
    push_entry_o.frame.speed_low_byte     = frame_i.speed_low_byte;
    push_entry_o.frame.speed_high_byte    = frame_i.speed_high_byte;
    push_entry_o.frame.encoder_low_byte   = frame_i.encoder_low_byte;
    push_entry_o.frame.encoder_high_byte  = frame_i.encoder_high_byte;
  end

endmodule

`default_nettype wire

// ===== design/mffd_queue.sv =====
// Short queue of classified frames between the front and the back.
// Depends on mffd_pkg.
`default_nettype none

module mffd_queue
  import mffd_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_valid_i,
  input  wire entry_t  push_entry_i,
  output logic         push_ready_o,
  output logic         pop_valid_o,
  output entry_t       pop_entry_o,
  input  wire logic    pop_ready_i
);

  entry_t               mem_q [QUEUE_DEPTH];
  logic [QUEUE_PW-1:0]  wr_q, wr_d;
  logic [QUEUE_PW-1:0]  rd_q, rd_d;
  logic [QUEUE_CW-1:0]  count_q, count_d;
  logic                 push, pop;

  assign push_ready_o = (count_q != QUEUE_CW'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_entry_o  = mem_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_d = wr_q;
    rd_d = rd_q;
    if (push) begin
      wr_d = (wr_q == QUEUE_PW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop) begin
      rd_d = (rd_q == QUEUE_PW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    unique case ({push, pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_entry_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QUEUE_CW'(QUEUE_DEPTH))
    else $error("queue fill count exceeds its depth");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (count_q == $past(count_q) + 1'b1))
    else $error("queue count did not grow on a lone push");

endmodule

`default_nettype wire

// ===== design/mffd_back.sv =====
// Back of the decoder: per-slot filter and turn state, then a pipeline that
// scales speed and angles and holds the result. Depends on mffd_pkg and the
// result interface.
`default_nettype none

module mffd_back
  import mffd_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    pop_valid_i,
  input  wire entry_t  pop_entry_i,
  output logic         pop_ready_o,
  mffd_result_if.source result_o
);

  // Slot state.
  logic [SLOT_COUNT-1:0][23:0] filt_q;
  logic [SLOT_COUNT-1:0][15:0] prev_q;
  logic [SLOT_COUNT-1:0][15:0] turn_q;

  // Stage enables: a stage loads when it is empty or the next one moves.
  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4, pop;

  assign en4         = !v4_q || result_o.ready;
  assign en3         = !v3_q || en4;
  assign en2         = !v2_q || en3;
  assign en1         = !v1_q || en2;
  assign pop_ready_o = en1;
  assign pop         = pop_valid_i && en1;

  // ---------------- stage 1: state update ----------------
  logic signed [15:0] cur;
  logic [15:0]        enc;
  logic signed [23:0] old_filt;
  logic [15:0]        old_prev, old_turn;
  logic signed [27:0] fsum;
  logic [27:0]        fmag;
  logic [59:0]        fprod;
  logic [23:0]        fquot;
  logic [23:0]        filt_d;
  logic signed [16:0] enc_diff;
  logic [15:0]        turn_d;

  always_comb begin
    cur      = $signed({pop_entry_i.frame.current_high_byte,
                         pop_entry_i.frame.current_low_byte});
    enc      = {pop_entry_i.frame.encoder_high_byte, pop_entry_i.frame.encoder_low_byte};
    old_filt = '0;
    old_prev = '0;
    old_turn = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (pop_entry_i.slot == 2'(i)) begin
        old_filt = $signed(filt_q[i]);
        old_prev = prev_q[i];
        old_turn = turn_q[i];
      end
    end
    // old + 0.9 * 256 * 10 * current, then divided by ten with rounding.
    fsum  = 28'(old_filt) + (28'(cur) <<< 11) + (28'(cur) <<< 8);
    fmag  = (fsum[27] ? 28'(-fsum) : 28'(fsum)) + 28'd5;
    fprod = 60'(fmag) * 60'(RECIP10);
    fquot = fprod[58:35];
    filt_d = fsum[27] ? 24'(-fquot) : fquot;

    enc_diff = $signed({1'b0, enc}) - $signed({1'b0, old_prev});
    if (enc_diff > TURN_HALF) begin
      turn_d = old_turn - 16'd1;
    end else if (enc_diff < -TURN_HALF) begin
      turn_d = old_turn + 16'd1;
    end else begin
      turn_d = old_turn;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filt_q <= '0;
      prev_q <= '0;
      turn_q <= '0;
    end else begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        if (pop && pop_entry_i.matched && (pop_entry_i.slot == 2'(i))) begin
          filt_q[i] <= filt_d;
          prev_q[i] <= enc;
          turn_q[i] <= turn_d;
        end
      end
    end
  end

  logic               m1_q;
  logic [1:0]         s1_q;
  logic [7:0]         temp1_q;
  logic [23:0]        fc1_q;
  logic signed [15:0] spd1_q;
  logic [15:0]        enc1_q;
  logic signed [15:0] tc1_q;

  // An unmatched frame travels on with every field zero.
  always_ff @(posedge clk_i) begin
    if (en1) begin
      m1_q <= pop_entry_i.matched;
      if (pop_entry_i.matched) begin
        s1_q    <= pop_entry_i.slot;
        temp1_q <= pop_entry_i.frame.temperature_byte;
        fc1_q   <= filt_d;
        spd1_q  <= $signed({pop_entry_i.frame.speed_high_byte,
                            pop_entry_i.frame.speed_low_byte});
        enc1_q  <= enc;
        tc1_q   <= $signed(turn_d);
      end else begin
        s1_q    <= '0;
        temp1_q <= '0;
        fc1_q   <= '0;
        spd1_q  <= '0;
        enc1_q  <= '0;
        tc1_q   <= '0;
      end
    end
  end

  // ---------------- stage 2: products ----------------
  logic [15:0] spd_mag, tc_mag;

  assign spd_mag = spd1_q[15] ? 16'(-spd1_q) : 16'(spd1_q);
  assign tc_mag  = tc1_q[15] ? 16'(-tc1_q) : 16'(tc1_q);

  logic               m2_q;
  logic [1:0]         s2_q;
  logic [7:0]         temp2_q;
  logic [23:0]        fc2_q;
  logic [15:0]        enc2_q;
  logic signed [15:0] tc2_q;
  logic               spd_neg2_q;
  logic [15:0]        spd_mag2_q;
  logic [38:0]        spd_frac2_q;
  logic [50:0]        single2_q;
  logic [49:0]        total2_q;

  always_ff @(posedge clk_i) begin
    if (en2) begin
      m2_q        <= m1_q;
      s2_q        <= s1_q;
      temp2_q     <= temp1_q;
      fc2_q       <= fc1_q;
      enc2_q      <= enc1_q;
      tc2_q       <= tc1_q;
      spd_neg2_q  <= spd1_q[15];
      spd_mag2_q  <= spd_mag;
      spd_frac2_q <= 39'(spd_mag) * 39'(SPD_REM) + 39'(SPD_HALF);
      single2_q   <= 51'(enc1_q) * 51'(TWO_PI_Q32) + ROUND_Q32;
      total2_q    <= 50'(tc_mag) * 50'(TWO_PI_Q32);
    end
  end

  // ---------------- stage 3: reciprocal and rounding ----------------
  logic [22:0] spd_t;
  logic [49:0] total_rnd;
  logic [33:0] total_mag;

  assign spd_t     = spd_frac2_q[38:16];
  assign total_rnd = total2_q + ROUND_Q16;
  assign total_mag = total_rnd[49:16];

  logic               m3_q;
  logic [1:0]         s3_q;
  logic [7:0]         temp3_q;
  logic [23:0]        fc3_q;
  logic [15:0]        enc3_q;
  logic signed [15:0] tc3_q;
  logic               spd_neg3_q;
  logic [22:0]        spd_t3_q;
  logic [47:0]        spd_q3_q;
  logic [25:0]        spd_int3_q;
  logic [18:0]        single3_q;
  logic [34:0]        total3_q;

  always_ff @(posedge clk_i) begin
    if (en3) begin
      m3_q       <= m2_q;
      s3_q       <= s2_q;
      temp3_q    <= temp2_q;
      fc3_q      <= fc2_q;
      enc3_q     <= enc2_q;
      tc3_q      <= tc2_q;
      spd_neg3_q <= spd_neg2_q;
      spd_t3_q   <= spd_t;
      spd_q3_q   <= 48'(spd_t) * 48'(RECIP180);
      spd_int3_q <= 26'(spd_mag2_q) * 26'(SPD_INT);
      single3_q  <= single2_q[50:32];
      total3_q   <= tc2_q[15] ? 35'(-{1'b0, total_mag}) : {1'b0, total_mag};
    end
  end

  // ---------------- stage 4: correction and result register ----------------
  logic [15:0] q_est;
  logic [22:0] q_rem;
  logic [15:0] q_fix;
  logic [25:0] spd_rad_mag;
  logic [26:0] spd_rad;

  always_comb begin
    q_est       = spd_q3_q[47:32];
    q_rem       = spd_t3_q - 23'(23'(q_est) * 23'(SPD_DIV));
    q_fix       = (q_rem >= 23'(SPD_DIV)) ? q_est + 16'd1 : q_est;
    spd_rad_mag = spd_int3_q + 26'(q_fix);
    spd_rad     = spd_neg3_q ? 27'(-{1'b0, spd_rad_mag}) : {1'b0, spd_rad_mag};
  end

  logic               m4_q;
  logic [1:0]         s4_q;
  logic [7:0]         temp4_q;
  logic [23:0]        fc4_q;
  logic [26:0]        spd4_q;
  logic [15:0]        enc4_q;
  logic [18:0]        single4_q;
  logic signed [15:0] tc4_q;
  logic [34:0]        total4_q;

  always_ff @(posedge clk_i) begin
    if (en4) begin
      m4_q      <= m3_q;
      s4_q      <= s3_q;
      temp4_q   <= temp3_q;
      fc4_q     <= fc3_q;
      spd4_q    <= spd_rad;
      enc4_q    <= enc3_q;
      single4_q <= single3_q;
      tc4_q     <= tc3_q;
      total4_q  <= total3_q + 35'(single3_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= pop_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  assign result_o.valid             = v4_q;
  assign result_o.matched           = m4_q;
  assign result_o.slot_index        = s4_q;
  assign result_o.temperature       = temp4_q;
  assign result_o.filtered_current  = $signed(fc4_q);
  assign result_o.speed_rad         = $signed(spd4_q);
  assign result_o.encoder_value     = enc4_q;
  assign result_o.single_turn_angle = single4_q;
  assign result_o.turn_count        = tc4_q;
  assign result_o.multi_turn_angle  = $signed(total4_q);

  a_unmatched_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && !result_o.matched) |->
      (result_o.slot_index == '0) && (result_o.temperature == '0) &&
      (result_o.filtered_current == '0) && (result_o.speed_rad == '0) &&
      (result_o.encoder_value == '0) && (result_o.single_turn_angle == '0) &&
      (result_o.turn_count == '0) && (result_o.multi_turn_angle == '0))
    else $error("unmatched frame left a nonzero result field");

  a_unmatched_keeps_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !pop_entry_i.matched) |=>
      ($stable(filt_q) && $stable(prev_q) && $stable(turn_q)))
    else $error("unmatched frame changed slot state");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pop_ready_o |-> (v1_q && v2_q && v3_q && v4_q && !result_o.ready))
    else $error("back pipeline refused a frame while it had room");

endmodule

`default_nettype wire

// ===== design/motor_feedback_frame_decoder.sv =====
// Top level of the motor feedback frame decoder: front, queue and back.
// Depends on mffd_pkg, the channel interfaces, mffd_front, mffd_queue and mffd_back.
`default_nettype none

// The decoder takes one received CAN feedback frame per cycle while the queue
// has room and returns one result per frame, in order. The front compares
// the frame identifier with the identifiers of the first active_slots slots
// (lowest slot wins) and drops the classified frame into a two-entry queue,
// so frames are still taken while the result side stalls, as long as the
// queue has room. The back pops one frame per cycle while its stages can
// move; its first stage reads and writes the matched slot's filtered current,
// previous encoder value and turn counter in that same cycle, so frames for
// the same slot may follow each other with no gap. Three more stages scale
// speed to rad/s, the encoder value to radians and the turn count to a total
// angle; the last of them is the result register. Sustained rate is one frame
// per clock cycle when nothing stalls. An accepted frame passes through its
// queue entry and back stages one to three before the result register loads.
// A frame that matches no active slot returns matched low with every other
// field zero and leaves all slot state untouched. The configuration port is
// always ready and should be written only while no frame is in flight; writes
// to indexes beyond the slot identifier registers are ignored.
module motor_feedback_frame_decoder
  import mffd_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  mffd_cfg_if.sink       cfg_i,
  mffd_frame_if.sink     frame_i,
  mffd_result_if.source  result_o
);

  // Front to queue.
  logic   push_valid;
  entry_t push_entry;
  logic   push_ready;

  // Queue to back.
  logic   pop_valid;
  entry_t pop_entry;
  logic   pop_ready;

  mffd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_i),
    .frame_i      (frame_i),
    .push_valid_o (push_valid),
    .push_entry_o (push_entry),
    .push_ready_i (push_ready)
  );

  mffd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_entry_i (push_entry),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_entry_o  (pop_entry),
    .pop_ready_i  (pop_ready)
  );

  mffd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_entry_i (pop_entry),
    .pop_ready_o (pop_ready),
    .result_o    (result_o)
  );

endmodule

`default_nettype wire

// ===== tb/sv/motor_feedback_frame_decoder_test.sv =====
// Self-checking testbench of motor_feedback_frame_decoder: directed and random frames
// are checked against a cycle-free predictor of the decoder kept inside this module.
// Depends on mffd_pkg, the mffd channel interfaces and the decoder RTL.
module motor_feedback_frame_decoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mffd_pkg::*;

  // round(pi * 2^32) and twice that: the radian scale of speed and angle.
  localparam longint HALF_TURN_Q32 = 64'sd13493037705;
  localparam longint FULL_TURN_Q32 = 2 * HALF_TURN_Q32;
  // Deg/s to rad/s divides by 180 after taking the Q32 scale down to Q16.
  localparam longint SPEED_DIVISOR = 180 * 65536;

  // Even the longest gaps and stalls on every frame keep a correct run well
  // below this, so it only catches a hang.
  localparam int CYCLE_LIMIT = 200_000;
  // A quiet tail after every outstanding result has been taken.
  localparam int DRAIN_CYCLES = 12;
  localparam int HITS_PER_PHASE = 75;
  localparam int RANDOM_PHASES = 4;
  // Register indexes past the last identifier register are not decoded.
  localparam logic [2:0] CFG_FIRST_UNUSED = 3'(CFG_SLOT3_ID) + 3'd1;
  localparam logic [15:0] HALF_RANGE = 16'h8000;

  // One decoded result, every field held as raw bits at its port width.
  typedef struct packed {
    logic        matched;
    logic [1:0]  slot_index;
    logic [7:0]  temperature;
    logic [23:0] filtered_current;
    logic [26:0] speed_rad;
    logic [15:0] encoder_value;
    logic [18:0] single_turn_angle;
    logic [15:0] turn_count;
    logic [34:0] multi_turn_angle;
  } decoded_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  mffd_cfg_if    cfg_bus ();
  mffd_frame_if  frame_bus ();
  mffd_result_if result_bus ();

  motor_feedback_frame_decoder i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_bus),
    .frame_i  (frame_bus),
    .result_o (result_bus)
  );

  always #2 clk_i = ~clk_i;

  // Shadow copy of the decoder: configuration registers and per-slot state.
  logic [2:0]  active_slots_q;
  logic [10:0] slot_ids [ID_REGS];
  longint      filter_store [SLOT_COUNT];
  logic [15:0] prev_encoder [SLOT_COUNT];
  logic [15:0] turn_counts [SLOT_COUNT];

  // Results predicted for accepted frame requests, oldest first.
  decoded_t awaited_decodes [$];

  int mismatches = 0;
  int cycles = 0;
  // Idling switches: frame gaps on the sending side, stalls on the result side.
  bit gaps_on = 1'b1;
  bit stalls_on = 1'b1;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("motor_feedback_frame_decoder verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Division rounded to nearest, halves away from zero.
  function automatic longint round_div(longint num, longint den);
    if (num >= 0) return (num + den / 2) / den;
    return -((-num + den / 2) / den);
  endfunction

  // Lowest active slot whose identifier matches, or -1. An active_slots value
  // above the slot count simply searches every slot.
  function automatic int find_slot(logic [10:0] id);
    int searched;
    int i;
    searched = (active_slots_q > SLOT_COUNT) ? SLOT_COUNT : int'(active_slots_q);
    for (i = 0; i < searched; i++) begin
      if (slot_ids[i] == id) return i;
    end
    return -1;
  endfunction

  // Decodes one frame and advances the matched slot's filter and turn state.
  function automatic decoded_t decode_frame(frame_t item);
    decoded_t res;
    int slot;
    logic signed [15:0] current;
    logic signed [15:0] speed;
    logic signed [15:0] turn_now;
    logic [15:0] enc;
    longint filtered;
    longint speed_q16;
    longint angle;
    longint step;
    res = '0;
    slot = find_slot(item.frame_id);
    // An unmatched frame reports all zeros and touches no slot state.
    if (slot < 0) return res;
    current = {item.current_high_byte, item.current_low_byte};
    speed = {item.speed_high_byte, item.speed_low_byte};
    enc = {item.encoder_high_byte, item.encoder_low_byte};

    // IIR: one tenth of the old Q8 value plus nine tenths of the new sample.
    filtered = round_div(filter_store[slot] + 9 * longint'(current) * 256, 10);
    filter_store[slot] = filtered;

    speed_q16 = round_div(longint'(speed) * HALF_TURN_Q32, SPEED_DIVISOR);
    angle = (longint'(enc) * FULL_TURN_Q32 + (longint'(1) <<< 31)) >>> 32;

    // A jump of more than half a turn is taken as a wrap through zero; a jump
    // of exactly half a turn is ambiguous and counts as no wrap.
    step = longint'(enc) - longint'(prev_encoder[slot]);
    if (step > 32768) turn_counts[slot] = turn_counts[slot] - 16'd1;
    else if (step < -32768) turn_counts[slot] = turn_counts[slot] + 16'd1;
    prev_encoder[slot] = enc;
    turn_now = turn_counts[slot];

    res.matched = 1'b1;
    res.slot_index = 2'(slot);
    res.temperature = item.temperature_byte;
    res.filtered_current = filtered[23:0];
    res.speed_rad = speed_q16[26:0];
    res.encoder_value = enc;
    res.single_turn_angle = angle[18:0];
    res.turn_count = turn_now;
    res.multi_turn_angle =
      35'(round_div(longint'(turn_now) * FULL_TURN_Q32, 65536) + angle);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic frame_t make_frame(logic [10:0] id, logic [7:0] temp,
                                        logic [15:0] current, logic [15:0] speed,
                                        logic [15:0] enc);
    frame_t f;
    f.frame_id = id;
    f.temperature_byte = temp;
    f.current_low_byte = current[7:0];
    f.current_high_byte = current[15:8];
    f.speed_low_byte = speed[7:0];
    f.speed_high_byte = speed[15:8];
    f.encoder_low_byte = enc[7:0];
    f.encoder_high_byte = enc[15:8];
    return f;
  endfunction

  // A 16-bit sample that lands on a signed or unsigned extreme now and then.
  function automatic logic [15:0] biased_word();
    case ($urandom_range(0, 15))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic frame_t random_frame(logic [10:0] id, logic [15:0] enc);
    return make_frame(id, 8'($urandom), biased_word(), biased_word(), enc);
  endfunction

  // Mostly plausible shaft motion, sometimes a jump right at half a turn,
  // sometimes a position anywhere.
  function automatic logic [15:0] next_encoder(logic [15:0] prev);
    case ($urandom_range(0, 9))
      6: return prev + HALF_RANGE + 16'($urandom_range(0, 2)) - 16'd1;
      7: return prev - HALF_RANGE + 16'($urandom_range(0, 2)) - 16'd1;
      8, 9: return 16'($urandom);
      default: return prev + 16'($urandom_range(0, 48000)) - 16'd24000;
    endcase
  endfunction

  // Idle lengths: the short range is drawn 85 times in 100, the long range otherwise.
  function automatic int pause_length();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int frame_gap();
    if (!gaps_on || $urandom_range(0, 2) != 0) return 0;
    return pause_length();
  endfunction

  task automatic drive_frame(frame_t f);
    frame_bus.frame_id <= f.frame_id;
    frame_bus.temperature_byte <= f.temperature_byte;
    frame_bus.current_low_byte <= f.current_low_byte;
    frame_bus.current_high_byte <= f.current_high_byte;
    frame_bus.speed_low_byte <= f.speed_low_byte;
    frame_bus.speed_high_byte <= f.speed_high_byte;
    frame_bus.encoder_low_byte <= f.encoder_low_byte;
    frame_bus.encoder_high_byte <= f.encoder_high_byte;
  endtask

  // Offers one frame request and returns once it is accepted. Valid stays high
  // afterwards, so back-to-back requests keep it high without a break; it only
  // falls when a gap is chosen or the sender goes idle.
  task automatic send_frame(input frame_t item, output logic hit);
    int gap;
    decoded_t want;
    gap = frame_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      // Garbage on the payload while valid is low must be ignored.
      frame_bus.valid <= 1'b0;
      drive_frame(random_frame(11'($urandom), 16'($urandom)));
      repeat (gap) @(negedge clk_i);
    end
    frame_bus.valid <= 1'b1;
    drive_frame(item);
    do @(posedge clk_i); while (frame_bus.ready !== 1'b1);
    want = decode_frame(item);
    awaited_decodes.push_back(want);
    hit = want.matched;
  endtask

  // Register write request; the shadow copy follows once it is accepted.
  task automatic write_reg(logic [2:0] index, logic [10:0] value);
    @(negedge clk_i);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= index;
    cfg_bus.data <= value;
    do @(posedge clk_i); while (cfg_bus.ready !== 1'b1);
    case (index)
      CFG_ACTIVE_SLOTS: active_slots_q = value[2:0];
      CFG_SLOT0_ID, CFG_SLOT1_ID, CFG_SLOT2_ID, CFG_SLOT3_ID:
        slot_ids[index - 3'(CFG_SLOT0_ID)] = value;
      default: ;  // unused indexes are dropped by the decoder
    endcase
    @(negedge clk_i);
    cfg_bus.valid <= 1'b0;
  endtask

  // Stops sending and lets every frame in flight come out, so that the
  // configuration can be changed with the pipeline empty.
  task automatic settle_idle();
    @(negedge clk_i);
    frame_bus.valid <= 1'b0;
    while (awaited_decodes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure and the checker
  // ---------------------------------------------------------------------------

  initial begin : result_ready_driver
    int hold;
    hold = 0;
    result_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold > 0) begin
        hold--;
        result_bus.ready <= 1'b0;
      end else if (stalls_on && $urandom_range(0, 5) == 0) begin
        hold = pause_length() - 1;
        result_bus.ready <= 1'b0;
      end else begin
        result_bus.ready <= 1'b1;
      end
    end
  end

  task automatic check_field(string name, logic [34:0] want, logic [34:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // Every accepted result is compared with the oldest outstanding prediction.
  // Signed ports are part-selected so both sides compare as plain bits.
  initial begin : result_checker
    decoded_t want;
    forever begin
      @(posedge clk_i);
      if (result_bus.valid === 1'b1 && result_bus.ready === 1'b1) begin
        if (awaited_decodes.size() == 0) begin
          $error("result returned with no frame outstanding");
          mismatches++;
        end else begin
          want = awaited_decodes.pop_front();
          check_field("matched", want.matched, result_bus.matched);
          check_field("slot_index", want.slot_index, result_bus.slot_index);
          check_field("temperature", want.temperature, result_bus.temperature);
          check_field("filtered_current", want.filtered_current,
                      result_bus.filtered_current[23:0]);
          check_field("speed_rad", want.speed_rad, result_bus.speed_rad[26:0]);
          check_field("encoder_value", want.encoder_value, result_bus.encoder_value);
          check_field("single_turn_angle", want.single_turn_angle,
                      result_bus.single_turn_angle);
          check_field("turn_count", want.turn_count, result_bus.turn_count[15:0]);
          check_field("multi_turn_angle", want.multi_turn_angle,
                      result_bus.multi_turn_angle[34:0]);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Out of reset no slot is active, so even the default identifiers miss.
  task automatic test_unmatched_after_reset();
    logic hit;
    send_frame(make_frame(ID_RESET_BASE, 8'hFF, 16'h7FFF, 16'h7FFF, 16'hFFFF), hit);
    send_frame(make_frame(11'h000, 8'h00, 16'h8000, 16'h8000, 16'h0000), hit);
    send_frame(make_frame(11'h7FF, 8'hA5, 16'h1234, 16'hFEDC, 16'h8000), hit);
  endtask

  // Default identifiers, then edge identifiers with a duplicate (the lower
  // slot must win) and writes to indexes that decode to no register.
  task automatic test_register_map();
    logic hit;
    int i;
    settle_idle();
    write_reg(CFG_ACTIVE_SLOTS, 11'd4);
    send_frame(make_frame(ID_RESET_BASE, 8'h00, 16'h7FFF, 16'h7FFF, 16'hFFFF), hit);
    send_frame(make_frame(ID_RESET_BASE + 11'd1, 8'hFF, 16'h8000, 16'h8000, 16'h0000), hit);
    send_frame(make_frame(ID_RESET_BASE + 11'd2, 8'h5A, 16'hFFFF, 16'h0001, 16'h7FFF), hit);
    send_frame(make_frame(ID_RESET_BASE + 11'd3, 8'hA5, 16'h0000, 16'hFFFF, 16'h8000), hit);

    settle_idle();
    write_reg(CFG_SLOT0_ID, 11'h000);
    write_reg(CFG_SLOT1_ID, 11'h7FF);
    write_reg(CFG_SLOT2_ID, 11'h7FF);
    write_reg(CFG_SLOT3_ID, 11'h555);
    for (i = 0; i < 3; i++) write_reg(CFG_FIRST_UNUSED + 3'(i), 11'h7FF - 11'(i));
    send_frame(make_frame(11'h000, 8'hFF, 16'h7FFF, 16'h7FFF, 16'hFFFF), hit);
    send_frame(make_frame(11'h000, 8'h00, 16'h7FFF, 16'h8000, 16'h0000), hit);
    send_frame(make_frame(11'h7FF, 8'h80, 16'h8000, 16'h7FFF, 16'hFFFF), hit);
    send_frame(make_frame(11'h555, 8'h7F, 16'h8000, 16'h8000, 16'h0001), hit);
    send_frame(make_frame(ID_RESET_BASE, 8'h11, 16'h2222, 16'h3333, 16'h4444), hit);
  endtask

  // Wrap detection on slot zero: full-scale jumps both ways, exact half-range
  // jumps that must not count, and jumps just past half range that must.
  task automatic test_turn_tracking();
    logic hit;
    logic [15:0] path [7];
    int i;
    path = '{16'h0000, 16'hFFFF, 16'h0000, 16'h8000, 16'h0000, 16'h8001, 16'h0000};
    for (i = 0; i < 7; i++) begin
      send_frame(make_frame(11'h000, 8'(i), 16'h0100, 16'hFF00, path[i]), hit);
    end
  endtask

  // Too many slots behaves as all slots; fewer slots hide the upper ones;
  // zero slots hides everything.
  task automatic test_slot_limits();
    logic hit;
    settle_idle();
    write_reg(CFG_ACTIVE_SLOTS, 11'd7);
    send_frame(make_frame(11'h555, 8'h42, 16'h0042, 16'h0042, 16'h1000), hit);
    settle_idle();
    write_reg(CFG_ACTIVE_SLOTS, 11'd1);
    send_frame(make_frame(11'h555, 8'h43, 16'h0043, 16'h0043, 16'h2000), hit);
    send_frame(make_frame(11'h000, 8'h44, 16'h0044, 16'h0044, 16'h3000), hit);
    settle_idle();
    write_reg(CFG_ACTIVE_SLOTS, 11'd0);
    send_frame(make_frame(11'h000, 8'h45, 16'h0045, 16'h0045, 16'h4000), hit);
  endtask

  // Phases of random traffic under different slot settings. Most frames carry
  // an active identifier with a plausible encoder path for that slot; the
  // rest are random identifiers that usually miss.
  task automatic test_random_traffic();
    logic hit;
    logic [2:0] active;
    logic [10:0] ids [ID_REGS];
    logic [10:0] id;
    logic [15:0] enc;
    int phase;
    int hits;
    int i;
    int slot;
    int searched;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      settle_idle();
      for (i = 0; i < ID_REGS; i++) ids[i] = 11'($urandom);
      case (phase)
        0: active = 3'd4;
        1: begin
          active = 3'd1;
          ids[0] = 11'h000;
        end
        2: begin
          active = 3'd7;
          ids[0] = 11'h7FF;
          ids[1] = 11'h000;
          ids[2] = 11'h7FF;
        end
        default: active = 3'($urandom_range(1, 7));
      endcase
      // Only the low three bits of the slot count are kept.
      write_reg(CFG_ACTIVE_SLOTS, {8'($urandom), active});
      for (i = 0; i < ID_REGS; i++) write_reg(3'(CFG_SLOT0_ID) + 3'(i), ids[i]);
      write_reg(CFG_FIRST_UNUSED + 3'($urandom_range(0, 2)), 11'($urandom));

      searched = (active > SLOT_COUNT) ? SLOT_COUNT : int'(active);
      hits = 0;
      while (hits < HITS_PER_PHASE) begin
        if ($urandom_range(0, 39) == 0) gaps_on = 1'($urandom);
        if ($urandom_range(0, 39) == 0) stalls_on = 1'($urandom);
        if ($urandom_range(0, 4) != 0) id = slot_ids[$urandom_range(0, searched - 1)];
        else id = 11'($urandom);
        slot = find_slot(id);
        enc = (slot >= 0) ? next_encoder(prev_encoder[slot]) : 16'($urandom);
        send_frame(random_frame(id, enc), hit);
        if (hit) hits++;
      end
    end
    gaps_on = 1'b1;
    stalls_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin : main_sequence
    int i;
    rst_ni = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = CFG_ACTIVE_SLOTS;
    cfg_bus.data = '0;
    frame_bus.valid = 1'b0;
    frame_bus.frame_id = '0;
    frame_bus.temperature_byte = '0;
    frame_bus.current_low_byte = '0;
    frame_bus.current_high_byte = '0;
    frame_bus.speed_low_byte = '0;
    frame_bus.speed_high_byte = '0;
    frame_bus.encoder_low_byte = '0;
    frame_bus.encoder_high_byte = '0;

    // Shadow state matches the decoder's reset values.
    active_slots_q = '0;
    for (i = 0; i < ID_REGS; i++) slot_ids[i] = ID_RESET_BASE + 11'(i);
    for (i = 0; i < SLOT_COUNT; i++) begin
      filter_store[i] = 0;
      prev_encoder[i] = '0;
      turn_counts[i] = '0;
    end

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_unmatched_after_reset();
    test_register_map();
    test_turn_tracking();
    test_slot_limits();
    test_random_traffic();

    // All requests are in; wait for the last results and a quiet tail.
    settle_idle();
    if (mismatches == 0) begin
      $display("motor_feedback_frame_decoder verification clean");
    end else begin
      $display("motor_feedback_frame_decoder verification failed");
    end
    $finish;
  end

endmodule

// ===== motor_feedback_frame_decoder.f =====
design/mffd_pkg.sv
design/mffd_channels.sv
design/mffd_front.sv
design/mffd_queue.sv
design/mffd_back.sv
design/motor_feedback_frame_decoder.sv
tb/sv/motor_feedback_frame_decoder_test.sv
